@@ rtl/ipb_pkg.sv @@
// Package for the IPv4 probe header builder.
// Holds the payload and header types, register and command codes, and the
// checksum helper functions. No dependencies.
package ipb_pkg;

    // Header geometry: five 32-bit words, 20 bytes.
    localparam int unsigned HDR_WORDS = 5;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_WORDS);
    localparam int unsigned CFG_IDX_W = 2;

    // Fixed header fields.
    localparam logic [7:0]  VER_IHL   = 8'h45;
    localparam logic [7:0]  TOS       = 8'h00;
    localparam logic [31:0] ID_FLAGS  = 32'h0000_4000;
    localparam logic [15:0] LEN_RESET = 16'd20;

    // Protocol numbers.
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_DCCP = 8'd33;

    typedef enum logic [0:0] {
        CMD_BUILD  = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_ADDR     = 2'd0,
        CFG_DEST_ADDR       = 2'd1,
        CFG_PACKET_LENGTH   = 2'd2,
        CFG_PROTOCOL_SELECT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_UDP  = 2'd0,
        SEL_TCP  = 2'd1,
        SEL_ICMP = 2'd2,
        SEL_DCCP = 2'd3
    } t_proto_sel;

    // Input transaction payload.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ttl;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [31:0]          header_word;
        logic [HDR_IDX_W-1:0] word_index;
        logic                 last_word;
    } t_out;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] packet_length;
        t_proto_sel  protocol_select;
    } t_cfg;

    // Whole header, word 0 first on the wire.
    typedef logic [HDR_WORDS-1:0][31:0] t_hdr;

    // Status from the emitter to the top level.
    typedef struct packed {
        logic free;
    } t_emit_status;

    // Protocol number for a protocol select code.
    function automatic logic [7:0] proto_code(input t_proto_sel sel);
        logic [7:0] code;
        unique case (sel)
            SEL_UDP:  code = PROTO_UDP;
            SEL_TCP:  code = PROTO_TCP;
            SEL_ICMP: code = PROTO_ICMP;
            SEL_DCCP: code = PROTO_DCCP;
            default:  code = PROTO_UDP;
        endcase
        return code;
    endfunction

    // Two end-around-carry folds of a 19-bit sum of 16-bit words. The fixed
    // header fields keep the nine-word build sum well inside 19 bits.
    function automatic logic [15:0] fold16(input logic [18:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        return s2[15:0];
    endfunction

endpackage

@@ rtl/ipv4_probe_header_builder.sv @@
// Top level of the IPv4 probe header builder.
// Holds the configuration registers and the input register, and joins
// ipb_hdr_calc and ipb_emitter. Depends on ipb_pkg.
//
// Usage:
//   Configuration writes arrive on the cfg channel (index 0 source address,
//   1 destination address, 2 packet length, 3 protocol select); it is always
//   ready and should only be written while the block is idle.
//   Each input transaction carries a command (build or TTL update) and a TTL.
//   Each command yields five output transactions, the header words 0 to 4,
//   with last_word set on word 4.
//   An accepted command waits in the input register, is loaded into the header
//   store once the emitter is free, and word 0 is then offered from the store.
//   Header rate is set by the single 32-bit output port, which carries five
//   words per header. One further command is held in the input register while
//   the previous header is still being sent, and it is loaded on the same edge
//   at which the last word is taken.
//   Stalls: when the receiver drops ready, the current word is held and the
//   input channel stops once its register is full.
//   Reset clears the header store to zero, empties both stages and restores
//   the register reset values (packet length 20, all else zero).
module ipv4_probe_header_builder import ipb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cfg         r_cfg;
    t_cfg         n_cfg;
    logic         r_in_valid;
    t_in          r_in;
    logic         load;
    t_hdr         cur_hdr;
    t_hdr         new_hdr;
    t_emit_status emit_status;

    // Configuration register decode.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_ADDR:     n_cfg.source_addr     = i_cfg_data;
                CFG_DEST_ADDR:       n_cfg.dest_addr       = i_cfg_data;
                CFG_PACKET_LENGTH:   n_cfg.packet_length   = i_cfg_data[15:0];
                CFG_PROTOCOL_SELECT: n_cfg.protocol_select = t_proto_sel'(i_cfg_data[1:0]);
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_addr     <= '0;
            r_cfg.dest_addr       <= '0;
            r_cfg.packet_length   <= LEN_RESET;
            r_cfg.protocol_select <= SEL_UDP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input register: refilled in the same cycle its command is loaded.
    assign load       = r_in_valid && emit_status.free;
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Header computation between the input register and the header store.
    ipb_hdr_calc u_calc (
        .i_cmd     (r_in.cmd),
        .i_ttl     (r_in.ttl),
        .i_cfg     (r_cfg),
        .i_old_hdr (cur_hdr),
        .o_new_hdr (new_hdr)
    );

    // Header store and word output.
    ipb_emitter u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_new_hdr   (new_hdr),
        .o_hdr       (cur_hdr),
        .o_status    (emit_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/ipb_hdr_calc.sv @@
// Header computation for the IPv4 probe header builder.
// Builds a fresh header with a full checksum, or rewrites the TTL of the
// stored header with an incremental checksum update. Depends on ipb_pkg.
module ipb_hdr_calc import ipb_pkg::*; (
    input  t_cmd       i_cmd,
    input  logic [7:0] i_ttl,
    input  t_cfg       i_cfg,
    input  t_hdr       i_old_hdr,
    output t_hdr       o_new_hdr
);

    logic [7:0]  proto_new;
    logic [31:0] bw0;
    logic [15:0] b_ttl_proto;
    logic [18:0] b_sum;
    logic [15:0] b_csum;
    logic [31:0] old_w2;
    logic [7:0]  old_proto;
    logic [15:0] u_ttl_proto;
    logic [18:0] u_sum;
    logic [15:0] u_csum;

    // Full build: sum the ten 16-bit words with the checksum field at zero.
    always_comb begin
        proto_new   = proto_code(i_cfg.protocol_select);
        bw0         = {VER_IHL, TOS, i_cfg.packet_length};
        b_ttl_proto = {i_ttl, proto_new};
        b_sum = {3'd0, bw0[31:16]} + {3'd0, bw0[15:0]}
              + {3'd0, ID_FLAGS[31:16]} + {3'd0, ID_FLAGS[15:0]}
              + {3'd0, b_ttl_proto}
              + {3'd0, i_cfg.source_addr[31:16]} + {3'd0, i_cfg.source_addr[15:0]}
              + {3'd0, i_cfg.dest_addr[31:16]} + {3'd0, i_cfg.dest_addr[15:0]};
        b_csum = ~fold16(b_sum);
    end

    // Incremental update: the complement of the sum of the inverted old
    // checksum, the inverted old TTL:protocol word and the new one.
    always_comb begin
        old_w2      = i_old_hdr[2];
        old_proto   = old_w2[23:16];
        u_ttl_proto = {i_ttl, old_proto};
        u_sum = {3'd0, ~old_w2[15:0]} + {3'd0, ~old_w2[31:16]} + {3'd0, u_ttl_proto};
        u_csum = ~fold16(u_sum);
    end

    // Select the resulting header.
    always_comb begin
        o_new_hdr = i_old_hdr;
        case (i_cmd)
            CMD_BUILD: begin
                o_new_hdr[0] = bw0;
                o_new_hdr[1] = ID_FLAGS;
                o_new_hdr[2] = {b_ttl_proto, b_csum};
                o_new_hdr[3] = i_cfg.source_addr;
                o_new_hdr[4] = i_cfg.dest_addr;
            end
            default: begin
                o_new_hdr[2] = {u_ttl_proto, u_csum};
            end
        endcase
    end

endmodule

@@ rtl/ipb_emitter.sv @@
// Header store and word emitter for the IPv4 probe header builder.
// Holds the current header and sends its five words out one per transaction.
// Depends on ipb_pkg.
module ipb_emitter import ipb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_hdr         i_new_hdr,
    output t_hdr         o_hdr,
    output t_emit_status o_status,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_out         o_out_data
);

    localparam logic [HDR_IDX_W-1:0] LAST_IDX = HDR_IDX_W'(HDR_WORDS - 1);

    t_hdr                 r_store;
    t_hdr                 n_store;
    logic [HDR_IDX_W-1:0] r_idx;
    logic [HDR_IDX_W-1:0] n_idx;
    logic                 r_busy;
    logic                 n_busy;
    logic                 is_last;
    logic                 take;

    // Output handshake and status.
    always_comb begin
        is_last         = (r_idx == LAST_IDX);
        take            = r_busy && i_out_ready;
        o_out_valid     = r_busy;
        o_status.free   = !r_busy || (take && is_last);
        o_out_data.header_word = r_store[r_idx];
        o_out_data.word_index  = r_idx;
        o_out_data.last_word   = is_last;
        o_hdr = r_store;
    end

    // Next state: a load restarts the word sequence from the new header.
    always_comb begin
        n_store = r_store;
        n_idx   = r_idx;
        n_busy  = r_busy;
        if (i_load) begin
            n_store = i_new_hdr;
            n_idx   = '0;
            n_busy  = 1'b1;
        end else if (take) begin
            if (is_last) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_idx   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_store <= n_store;
            r_idx   <= n_idx;
            r_busy  <= n_busy;
        end
    end

`ifndef SYNTHESIS
    // The word index never runs past the last header word.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("emitter word index out of range");

    // A load starts a new header at word 0.
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_busy && r_idx == '0))
        else $error("load did not restart at word 0");

    // Taking the last word with nothing new to load leaves the emitter idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && is_last && !i_load) |=> !r_busy)
        else $error("emitter still busy after last word");

    // The stored header only changes on a load.
    a_store_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_load) |=> $stable(r_store))
        else $error("header store changed without a load");
`endif

endmodule

@@ dv/tb.sv @@
// Testbench for ipv4_probe_header_builder: register writes, build and TTL update commands.
// Each command's five header words are predicted and checked against the output transactions.
// Depends on ipb_pkg and the RTL of the block.
module tb;
    import ipb_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned TAIL_CYCLES  = 6;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;

    // Local copy of the stored header and of the registers.
    logic [31:0] hdr_model [HDR_WORDS];
    logic [31:0] reg_src_addr;
    logic [31:0] reg_dst_addr;
    logic [15:0] reg_pkt_len;
    t_proto_sel  reg_proto_sel;

    // Header words still to come, oldest first.
    t_out        words_due [$];
    int unsigned fail_count = 0;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    int unsigned hold_req = 0;

    ipv4_probe_header_builder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Two end-around-carry folds of a 32-bit sum of 16-bit words.
    function automatic logic [15:0] csum_fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
        return t[15:0];
    endfunction

    // Mostly random values, with all zeros and all ones turning up often.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Apply one command to the header copy and queue the five words it emits.
    task automatic predict_header(input t_in item);
        logic [31:0] sum;
        logic [7:0]  proto;
        logic [15:0] prev_tp;
        logic [15:0] next_tp;
        int          i;
        if (item.cmd == CMD_BUILD) begin
            case (reg_proto_sel)
                SEL_UDP:  proto = PROTO_UDP;
                SEL_TCP:  proto = PROTO_TCP;
                SEL_ICMP: proto = PROTO_ICMP;
                default:  proto = PROTO_DCCP;
            endcase
            hdr_model[0] = {VER_IHL, TOS, reg_pkt_len};
            hdr_model[1] = ID_FLAGS;
            hdr_model[2] = {item.ttl, proto, 16'h0000};
            hdr_model[3] = reg_src_addr;
            hdr_model[4] = reg_dst_addr;
            sum = '0;
            for (i = 0; i < HDR_WORDS; i++) begin
                sum += {16'd0, hdr_model[i][31:16]} + {16'd0, hdr_model[i][15:0]};
            end
            hdr_model[2][15:0] = ~csum_fold(sum);
        end else begin
            // Only TTL changes; the checksum follows from the old TTL:protocol word.
            proto   = hdr_model[2][23:16];
            prev_tp = hdr_model[2][31:16];
            next_tp = {item.ttl, proto};
            sum = {16'd0, ~hdr_model[2][15:0]} + {16'd0, ~prev_tp} + {16'd0, next_tp};
            hdr_model[2] = {item.ttl, proto, ~csum_fold(sum)};
        end
        for (i = 0; i < HDR_WORDS; i++) begin
            words_due.push_back('{header_word: hdr_model[i],
                                  word_index:  HDR_IDX_W'(i),
                                  last_word:   (i == HDR_WORDS - 1)});
        end
    endtask

    // Offer one command and wait until the transaction is accepted.
    task automatic send_cmd(input t_cmd cmd, input logic [7:0] ttl);
        t_in item;
        item = '{cmd: cmd, ttl: ttl};
        if (send_gaps && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        predict_header(item);
    endtask

    // Stop offering commands and wait until the block has gone idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SOURCE_ADDR:   reg_src_addr  = data;
            CFG_DEST_ADDR:     reg_dst_addr  = data;
            CFG_PACKET_LENGTH: reg_pkt_len   = data[15:0];
            default:           reg_proto_sel = t_proto_sel'(data[1:0]);
        endcase
        @(posedge i_clk);
    endtask

    // A TTL update straight after reset works on the all-zero header.
    task automatic test_update_before_build();
        send_cmd(CMD_UPDATE, 8'h40);
        send_cmd(CMD_UPDATE, 8'hFF);
    endtask

    // Builds with the register reset values and the TTL extremes, then an update.
    task automatic test_reset_registers();
        send_cmd(CMD_BUILD, 8'h00);
        send_cmd(CMD_BUILD, 8'hFF);
        send_cmd(CMD_UPDATE, 8'h01);
    endtask

    // Every protocol selection, each followed by an update.
    task automatic test_protocols();
        t_proto_sel sels [4];
        int         k;
        sels = '{SEL_UDP, SEL_TCP, SEL_ICMP, SEL_DCCP};
        for (k = 0; k < 4; k++) begin
            settle();
            write_reg(CFG_PROTOCOL_SELECT, {30'd0, sels[k]});
            send_cmd(CMD_BUILD, 8'($urandom_range(255)));
            send_cmd(CMD_UPDATE, 8'($urandom_range(255)));
        end
    endtask

    // Addresses and length at all ones, then at zero.
    task automatic test_register_extremes();
        settle();
        write_reg(CFG_SOURCE_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_DEST_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_PACKET_LENGTH, 32'h0000_FFFF);
        send_cmd(CMD_BUILD, 8'hFF);
        send_cmd(CMD_UPDATE, 8'h00);
        settle();
        write_reg(CFG_SOURCE_ADDR, 32'h0000_0000);
        write_reg(CFG_DEST_ADDR, 32'h0000_0000);
        write_reg(CFG_PACKET_LENGTH, 32'h0000_0000);
        send_cmd(CMD_BUILD, 8'h00);
        send_cmd(CMD_UPDATE, 8'hFF);
    endtask

    // Register changes after a build must not reach the header through an update.
    task automatic test_update_ignores_registers();
        settle();
        write_reg(CFG_SOURCE_ADDR, $urandom());
        write_reg(CFG_DEST_ADDR, $urandom());
        write_reg(CFG_PACKET_LENGTH, {16'd0, 16'($urandom())});
        send_cmd(CMD_BUILD, 8'($urandom_range(255)));
        settle();
        write_reg(CFG_SOURCE_ADDR, $urandom());
        write_reg(CFG_DEST_ADDR, $urandom());
        write_reg(CFG_PACKET_LENGTH, {16'd0, 16'($urandom())});
        write_reg(CFG_PROTOCOL_SELECT, {30'd0, 2'($urandom_range(3))});
        send_cmd(CMD_UPDATE, 8'($urandom_range(255)));
        send_cmd(CMD_UPDATE, 8'($urandom_range(255)));
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_back_pressure();
        int k;
        settle();
        send_gaps = 1'b0;
        hold_req  = 80;
        for (k = 0; k < 10; k++) begin
            send_cmd(t_cmd'($urandom_range(1)), 8'($urandom_range(255)));
        end
        settle();
        send_gaps = 1'b1;
    endtask

    // Phases of random register settings and random build and update commands.
    task automatic test_random();
        logic [31:0] w;
        int          p;
        int          k;
        for (p = 0; p < PHASES; p++) begin
            settle();
            // The first phase runs without any idling on either side.
            send_gaps = (p != 0);
            recv_gaps = (p != 0);
            write_reg(CFG_SOURCE_ADDR, rand_word());
            write_reg(CFG_DEST_ADDR, rand_word());
            w = rand_word();
            write_reg(CFG_PACKET_LENGTH, {16'd0, w[15:0]});
            write_reg(CFG_PROTOCOL_SELECT, {30'd0, 2'($urandom_range(3))});
            for (k = 0; k < PHASE_ITEMS; k++) begin
                w = rand_word();
                send_cmd(($urandom_range(99) < 40) ? CMD_BUILD : CMD_UPDATE, w[7:0]);
            end
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (recv_gaps) begin
                i_out_ready <= ($urandom_range(99) >= 30);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transaction, taken at the coming edge, with the oldest expectation.
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (words_due.size() == 0) begin
                $error("unexpected header word %h at index %0d",
                       o_out_data.header_word, o_out_data.word_index);
                fail_count++;
            end else begin
                want = words_due.pop_front();
                if (o_out_data.header_word !== want.header_word) begin
                    $error("header_word: expected %h, got %h",
                           want.header_word, o_out_data.header_word);
                    fail_count++;
                end
                if (o_out_data.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, o_out_data.word_index);
                    fail_count++;
                end
                if (o_out_data.last_word !== want.last_word) begin
                    $error("last_word: expected %0d, got %0d",
                           want.last_word, o_out_data.last_word);
                    fail_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        int i;
        for (i = 0; i < HDR_WORDS; i++) begin
            hdr_model[i] = '0;
        end
        reg_src_addr  = '0;
        reg_dst_addr  = '0;
        reg_pkt_len   = LEN_RESET;
        reg_proto_sel = SEL_UDP;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_update_before_build();
        test_reset_registers();
        test_protocols();
        test_register_extremes();
        test_update_ignores_registers();
        test_back_pressure();
        test_random();
        settle();
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("tb NOT OK");
        $finish;
    end

endmodule
